/* design/assert_macros.svh */
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define AST_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* design/phpv_pkg.sv */
package phpv_pkg;

  // Datapath operation codes
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;   // latch sample, form errors and dt
  localparam logic [4:0] OP_MSQ    = 5'd2;   // square of error
  localparam logic [4:0] OP_ASQ    = 5'd3;   // add square to sum
  localparam logic [4:0] OP_SQGO   = 5'd4;   // start square root
  localparam logic [4:0] OP_MDER   = 5'd5;   // error delta times 1e6
  localparam logic [4:0] OP_DDER   = 5'd6;   // divide by dt
  localparam logic [4:0] OP_WDER   = 5'd7;   // store derivative
  localparam logic [4:0] OP_MG     = 5'd8;   // gain times value half
  localparam logic [4:0] OP_AG     = 5'd9;   // add gain term
  localparam logic [4:0] OP_WOUT   = 5'd10;  // store PID output
  localparam logic [4:0] OP_MFAR   = 5'd11;  // error times far limit
  localparam logic [4:0] OP_DFAR   = 5'd12;  // divide by distance
  localparam logic [4:0] OP_WFAR   = 5'd13;  // store capped velocity
  localparam logic [4:0] OP_CLRI   = 5'd14;  // clear position integrals
  localparam logic [4:0] OP_MACC   = 5'd15;  // error times dt
  localparam logic [4:0] OP_DACC   = 5'd16;  // divide by 1e6
  localparam logic [4:0] OP_WACC   = 5'd17;  // update integral
  localparam logic [4:0] OP_COMMIT = 5'd18;  // store errors, load output word

  // Gain selects
  localparam logic [1:0] G_P = 2'd0;
  localparam logic [1:0] G_I = 2'd1;
  localparam logic [1:0] G_D = 2'd2;

  // Axis indexes
  localparam logic [1:0] AX_X   = 2'd0;
  localparam logic [1:0] AX_Z   = 2'd2;
  localparam logic [1:0] AX_YAW = 2'd3;

  // Configuration register indexes
  localparam logic [3:0] CFG_TARGET_X  = 4'd0;
  localparam logic [3:0] CFG_TARGET_Y  = 4'd1;
  localparam logic [3:0] CFG_TARGET_Z  = 4'd2;
  localparam logic [3:0] CFG_GAIN_P    = 4'd3;
  localparam logic [3:0] CFG_GAIN_I    = 4'd4;
  localparam logic [3:0] CFG_GAIN_D    = 4'd5;
  localparam logic [3:0] CFG_FAR_LIMIT = 4'd6;
  localparam logic [3:0] CFG_RESET_GAP = 4'd7;

  localparam logic [31:0] US_PER_S = 32'd1000000;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] ax;
    logic [1:0] gsel;
    logic       hi;
  } cmd_t;

  typedef struct packed {
    logic far;
    logic sq_busy;
    logic div_busy;
  } stat_t;

endpackage

/* design/phpv_intf.sv */
// Pose sample channel
interface phpv_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] yaw_angle;
  logic        [31:0] stamp_us;
  modport source (output valid, pos_x, pos_y, pos_z, yaw_angle, stamp_us, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, yaw_angle, stamp_us, output ready);
endinterface

// Velocity command channel
interface phpv_vel_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] yaw_rate;
  logic               far_mode;
  logic               zero_interval;
  modport source (output valid, vel_x, vel_y, vel_z, yaw_rate, far_mode, zero_interval,
                  input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, yaw_rate, far_mode, zero_interval,
                  output ready);
endinterface

// Register write channel
interface phpv_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/phpv_dp.sv */
module phpv_dp (
  input  logic               clk,
  input  logic               rst,
  input  phpv_pkg::cmd_t     cmd,
  output phpv_pkg::stat_t    stat,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] yaw_angle,
  input  logic [31:0]        stamp_us,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] vel_z,
  output logic signed [31:0] yaw_rate,
  output logic               far_mode,
  output logic               zero_interval
);
  import phpv_pkg::*;

  localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
  // ceil(2^71 / 15625): x / 1e6 == ((x >> 6) * ACC_RECIP) >> 71 for x < 2^63
  localparam logic [57:0] ACC_RECIP = 58'(((128'd1 << 71) / 128'd15625) + 128'd1);

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic [47:0] mag48(input logic [47:0] v);
    return v[47] ? 48'(-v) : v;
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) return d[32] ? MIN32 : MAX32;
    return d[31:0];
  endfunction

  // Configuration registers
  logic signed [31:0] goal_x, goal_y, goal_z, gain_p, gain_i, gain_d;
  logic [30:0]        far_limit;
  logic [31:0]        reset_gap;

  // Controller state
  logic signed [31:0] err [4];
  logic signed [31:0] prev_err [4];
  logic signed [47:0] integ [4];
  logic signed [31:0] deriv [4];
  logic signed [31:0] vel [4];
  logic [31:0]        prev_stamp;
  logic [31:0]        dt;
  logic               zint;
  logic [63:0]        sumsq;
  logic [63:0]        prod;
  logic signed [63:0] acc;

  // Square root unit
  logic [63:0] sv;
  logic [31:0] radius;
  logic [35:0] srem;
  logic [4:0]  scnt;
  logic        sbusy;

  // Divider unit
  logic [63:0] dq;
  logic [31:0] drem;
  logic [31:0] dvsr;
  logic [5:0]  dcnt;
  logic        dbusy;

  // Reciprocal unit for the divide by one million
  logic [56:0]  ry;
  logic [115:0] racc;
  logic [115:0] rterm;
  logic [57:0]  rpp;
  logic [28:0]  rma, rmb;
  logic [1:0]   rcnt;
  logic         rbusy;

  // Operand selection
  logic [31:0] err_a, prev_a, dt_now, gsel_v, gmag;
  logic [47:0] integ_a, val48, vmag;
  logic [23:0] part;
  logic [32:0] dsub, dmag, ma;
  logic [31:0] mb;
  logic [64:0] mprod;
  logic [63:0] term;
  logic        dneg, vneg, gneg, dist_far;

  assign err_a   = err[cmd.ax];
  assign prev_a  = prev_err[cmd.ax];
  assign integ_a = integ[cmd.ax];
  assign dt_now  = stamp_us - prev_stamp;
  assign dsub    = {err_a[31], err_a} - {prev_a[31], prev_a};
  assign dneg    = dsub[32];
  assign dmag    = dneg ? 33'(-dsub) : dsub;
  assign dist_far = radius > {1'b0, far_limit};

  always_comb begin
    case (cmd.gsel)
      G_P:     gsel_v = gain_p;
      G_I:     gsel_v = gain_i;
      default: gsel_v = gain_d;
    endcase
    case (cmd.gsel)
      G_P:     val48 = {{16{err_a[31]}}, err_a};
      G_I:     val48 = integ_a;
      default: val48 = {{16{deriv[cmd.ax][31]}}, deriv[cmd.ax]};
    endcase
  end

  assign gneg = gsel_v[31];
  assign gmag = mag32(gsel_v);
  assign vneg = val48[47];
  assign vmag = mag48(val48);
  assign part = cmd.hi ? vmag[47:24] : vmag[23:0];
  assign term = cmd.hi ? {prod[55:0], 8'd0} : {16'd0, prod[63:16]};

  // Shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MSQ: begin
        ma = {1'b0, mag32(err_a)};
        mb = mag32(err_a);
      end
      OP_MDER: begin
        ma = dmag;
        mb = US_PER_S;
      end
      OP_MG: begin
        ma = {9'd0, part};
        mb = gmag;
      end
      OP_MFAR: begin
        ma = {1'b0, mag32(err_a)};
        mb = {1'b0, far_limit};
      end
      OP_MACC: begin
        ma = {1'b0, mag32(err_a)};
        mb = dt;
      end
      default: ;
    endcase
  end

  assign mprod = ma * mb;

  assign stat = '{far: dist_far, sq_busy: sbusy, div_busy: dbusy || rbusy};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x    <= '0;
      goal_y    <= '0;
      goal_z    <= 32'sd65536;
      gain_p    <= 32'sd65536;
      gain_i    <= '0;
      gain_d    <= '0;
      far_limit <= 31'd52429;
      reset_gap <= 32'd200000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_X:  goal_x    <= cfg_data;
        CFG_TARGET_Y:  goal_y    <= cfg_data;
        CFG_TARGET_Z:  goal_z    <= cfg_data;
        CFG_GAIN_P:    gain_p    <= cfg_data;
        CFG_GAIN_I:    gain_i    <= cfg_data;
        CFG_GAIN_D:    gain_d    <= cfg_data;
        CFG_FAR_LIMIT: far_limit <= cfg_data[30:0];
        CFG_RESET_GAP: reset_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  // Square root, one result bit a cycle
  logic [35:0] sr2, strial;
  assign sr2    = {srem[33:0], sv[63:62]};
  assign strial = {2'd0, radius, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
    end else if (cmd.op == OP_SQGO) begin
      sbusy <= 1'b1;
    end else if (sbusy && scnt == 5'd31) begin
      sbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQGO) begin
      sv     <= sumsq;
      srem   <= '0;
      radius <= '0;
      scnt   <= '0;
    end else if (sbusy) begin
      sv   <= {sv[61:0], 2'b00};
      scnt <= scnt + 5'd1;
      if (sr2 >= strial) begin
        srem   <= sr2 - strial;
        radius <= {radius[30:0], 1'b1};
      end else begin
        srem   <= sr2;
        radius <= {radius[30:0], 1'b0};
      end
    end
  end

  // Restoring divider, one quotient bit a cycle
  logic [32:0] dsh;
  logic        dstart;
  assign dsh    = {drem, dq[63]};
  assign dstart = (cmd.op == OP_DDER) || (cmd.op == OP_DFAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (dstart) begin
      dbusy <= 1'b1;
    end else if (dbusy && dcnt == 6'd63) begin
      dbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dstart) begin
      dq   <= prod;
      drem <= '0;
      dcnt <= '0;
      case (cmd.op)
        OP_DDER: dvsr <= dt;
        default: dvsr <= radius;
      endcase
    end else if (dbusy) begin
      dcnt <= dcnt + 6'd1;
      if (dsh >= {1'b0, dvsr}) begin
        drem <= 32'(dsh - {1'b0, dvsr});
        dq   <= {dq[62:0], 1'b1};
      end else begin
        drem <= dsh[31:0];
        dq   <= {dq[62:0], 1'b0};
      end
    end
  end

  // Reciprocal multiply: four 29x29 partial products, one a cycle
  always_comb begin
    case (rcnt)
      2'd0: begin
        rma = ry[28:0];
        rmb = ACC_RECIP[28:0];
      end
      2'd1: begin
        rma = ry[28:0];
        rmb = ACC_RECIP[57:29];
      end
      2'd2: begin
        rma = {1'b0, ry[56:29]};
        rmb = ACC_RECIP[28:0];
      end
      default: begin
        rma = {1'b0, ry[56:29]};
        rmb = ACC_RECIP[57:29];
      end
    endcase
    rpp = rma * rmb;
    case (rcnt)
      2'd0:    rterm = {58'd0, rpp};
      2'd3:    rterm = {rpp, 58'd0};
      default: rterm = {29'd0, rpp, 29'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rbusy <= 1'b0;
    end else if (cmd.op == OP_DACC) begin
      rbusy <= 1'b1;
    end else if (rbusy && rcnt == 2'd3) begin
      rbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DACC) begin
      ry   <= prod[62:6];
      racc <= '0;
      rcnt <= '0;
    end else if (rbusy) begin
      racc <= racc + rterm;
      rcnt <= rcnt + 2'd1;
    end
  end

  // Write-back values
  logic [31:0] der_val, far_val, out_val;
  logic [49:0] acc_sum, q50;
  logic [47:0] acc_val;

  always_comb begin
    if (dt == '0) begin
      der_val = '0;
    end else if (!dneg) begin
      der_val = (dq[63:31] != '0) ? MAX32 : dq[31:0];
    end else if (dq[63:32] != '0 || (dq[31] && dq[30:0] != '0)) begin
      der_val = MIN32;
    end else begin
      der_val = 32'(-dq[31:0]);
    end
    far_val = err_a[31] ? 32'(-dq[31:0]) : dq[31:0];
    q50     = {6'd0, racc[114:71]};
    acc_sum = {{2{integ_a[47]}}, integ_a} + (err_a[31] ? 50'(-q50) : q50);
    if (acc_sum[49:47] == 3'b000 || acc_sum[49:47] == 3'b111) acc_val = acc_sum[47:0];
    else acc_val = acc_sum[49] ? MIN48 : MAX48;
    if (acc[63:31] == {33{acc[31]}}) out_val = acc[31:0];
    else out_val = acc[63] ? MIN32 : MAX32;
  end

  // Sequenced datapath operations
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        prev_err[i] <= '0;
        integ[i]    <= '0;
      end
      prev_stamp <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          err[0] <= sat_sub(goal_x, pos_x);
          err[1] <= sat_sub(goal_y, pos_y);
          err[2] <= sat_sub(goal_z, pos_z);
          err[3] <= (yaw_angle == MIN32) ? MAX32 : 32'(-yaw_angle);
          dt     <= dt_now;
          zint   <= (dt_now == '0);
          prev_stamp <= stamp_us;
          sumsq  <= '0;
          acc    <= '0;
          if (dt_now > reset_gap) begin
            for (int i = 0; i < 4; i++) integ[i] <= '0;
          end
        end
        OP_ASQ:  sumsq <= sumsq + prod;
        OP_WDER: deriv[cmd.ax] <= der_val;
        OP_AG:   acc <= (gneg ^ vneg) ? acc - term : acc + term;
        OP_WOUT: begin
          vel[cmd.ax] <= out_val;
          acc <= '0;
        end
        OP_WFAR: vel[cmd.ax] <= far_val;
        OP_CLRI: begin
          for (int i = 0; i < 3; i++) integ[i] <= '0;
        end
        OP_WACC: integ[cmd.ax] <= acc_val;
        OP_COMMIT: begin
          for (int i = 0; i < 4; i++) prev_err[i] <= err[i];
        end
        default: ;
      endcase
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MSQ, OP_MDER, OP_MG, OP_MFAR, OP_MACC: prod <= mprod[63:0];
      default: ;
    endcase
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.op == OP_COMMIT) begin
      vel_x         <= vel[0];
      vel_y         <= vel[1];
      vel_z         <= vel[2];
      yaw_rate      <= vel[3];
      far_mode      <= dist_far;
      zero_interval <= zint;
    end
  end

endmodule

/* design/phpv_ctrl.sv */
module phpv_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output phpv_pkg::cmd_t  cmd,
  input  phpv_pkg::stat_t stat
);
  import phpv_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQM  = 5'd1;
  localparam logic [4:0] S_SQA  = 5'd2;
  localparam logic [4:0] S_SQG  = 5'd3;
  localparam logic [4:0] S_SQW  = 5'd4;
  localparam logic [4:0] S_DM   = 5'd5;
  localparam logic [4:0] S_DD   = 5'd6;
  localparam logic [4:0] S_DW   = 5'd7;
  localparam logic [4:0] S_GM   = 5'd8;
  localparam logic [4:0] S_GA   = 5'd9;
  localparam logic [4:0] S_GW   = 5'd10;
  localparam logic [4:0] S_FM   = 5'd11;
  localparam logic [4:0] S_FD   = 5'd12;
  localparam logic [4:0] S_FW   = 5'd13;
  localparam logic [4:0] S_FC   = 5'd14;
  localparam logic [4:0] S_AM   = 5'd15;
  localparam logic [4:0] S_AD   = 5'd16;
  localparam logic [4:0] S_AW   = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  logic [4:0] state, state_next;
  logic [1:0] ax, ax_next;
  logic [1:0] gsel, gsel_next;
  logic       hi, hi_next;
  logic       out_valid_next;
  logic       commit;

  assign in_ready = (state == S_IDLE);

  // Sequencer
  always_comb begin
    state_next = state;
    ax_next    = ax;
    gsel_next  = gsel;
    hi_next    = hi;
    commit     = 1'b0;
    cmd        = '{op: OP_NONE, ax: ax, gsel: gsel, hi: hi};
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          ax_next    = AX_X;
          state_next = S_SQM;
        end
      end
      S_SQM: begin
        cmd.op     = OP_MSQ;
        state_next = S_SQA;
      end
      S_SQA: begin
        cmd.op = OP_ASQ;
        if (ax == AX_Z) begin
          state_next = S_SQG;
        end else begin
          ax_next    = ax + 2'd1;
          state_next = S_SQM;
        end
      end
      S_SQG: begin
        cmd.op     = OP_SQGO;
        ax_next    = AX_X;
        state_next = S_SQW;
      end
      S_SQW: begin
        if (!stat.sq_busy) state_next = S_DM;
      end
      S_DM: begin
        cmd.op     = OP_MDER;
        state_next = S_DD;
      end
      S_DD: begin
        cmd.op     = OP_DDER;
        state_next = S_DW;
      end
      S_DW: begin
        if (!stat.div_busy) begin
          cmd.op = OP_WDER;
          if (ax == AX_YAW) begin
            gsel_next  = G_P;
            hi_next    = 1'b0;
            state_next = S_GM;
          end else begin
            ax_next    = ax + 2'd1;
            state_next = S_DM;
          end
        end
      end
      S_GM: begin
        cmd.op     = OP_MG;
        state_next = S_GA;
      end
      S_GA: begin
        cmd.op = OP_AG;
        if (!hi) begin
          hi_next    = 1'b1;
          state_next = S_GM;
        end else begin
          hi_next = 1'b0;
          if (gsel == G_D) begin
            state_next = S_GW;
          end else begin
            gsel_next  = gsel + 2'd1;
            state_next = S_GM;
          end
        end
      end
      S_GW: begin
        cmd.op    = OP_WOUT;
        gsel_next = G_P;
        if (ax == AX_YAW) begin
          ax_next    = AX_X;
          state_next = stat.far ? S_FM : S_GM;
        end else if (ax == AX_Z) begin
          ax_next    = AX_X;
          state_next = S_AM;
        end else begin
          ax_next    = ax + 2'd1;
          state_next = S_GM;
        end
      end
      S_FM: begin
        cmd.op     = OP_MFAR;
        state_next = S_FD;
      end
      S_FD: begin
        cmd.op     = OP_DFAR;
        state_next = S_FW;
      end
      S_FW: begin
        if (!stat.div_busy) begin
          cmd.op = OP_WFAR;
          if (ax == AX_Z) begin
            state_next = S_FC;
          end else begin
            ax_next    = ax + 2'd1;
            state_next = S_FM;
          end
        end
      end
      S_FC: begin
        cmd.op     = OP_CLRI;
        ax_next    = AX_YAW;
        state_next = S_AM;
      end
      S_AM: begin
        cmd.op     = OP_MACC;
        state_next = S_AD;
      end
      S_AD: begin
        cmd.op     = OP_DACC;
        state_next = S_AW;
      end
      S_AW: begin
        if (!stat.div_busy) begin
          cmd.op = OP_WACC;
          if (ax == AX_YAW) begin
            state_next = S_DONE;
          end else begin
            ax_next    = ax + 2'd1;
            state_next = S_AM;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_COMMIT;
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_next = out_valid;
    if (commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ax        <= AX_X;
      gsel      <= G_P;
      hi        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ax        <= ax_next;
      gsel      <= gsel_next;
      hi        <= hi_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* design/position_hold_pid_velocity.sv */
// Channel   Dir  Word
// sample    in   pos_x, pos_y, pos_z, yaw_angle, stamp_us
// command   out  vel_x, vel_y, vel_z, yaw_rate, far_mode, zero_interval
// cfg       in   index, data (register write, always ready)
//
// A sample passes through the 32-step square root, four derivative quotients
// from the bit-serial divider, three capped-velocity quotients in far mode
// and the four-step reciprocal divide for each integral update.
// Reset is synchronous; it restores the register defaults and clears state.
// A new sample is taken only while the sequencer is idle; a finished word
// waits in the output register while the next sample is worked on, and the
// sequencer holds in its last step while that word is still unread.
module position_hold_pid_velocity (
  input logic       clk,
  input logic       rst,
  phpv_pose_if.sink sample,
  phpv_vel_if.source command,
  phpv_cfg_if.sink  cfg
);
  import phpv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg.ready = 1'b1;

  phpv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (command.valid),
    .out_ready (command.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  phpv_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .pos_x         (sample.pos_x),
    .pos_y         (sample.pos_y),
    .pos_z         (sample.pos_z),
    .yaw_angle     (sample.yaw_angle),
    .stamp_us      (sample.stamp_us),
    .vel_x         (command.vel_x),
    .vel_y         (command.vel_y),
    .vel_z         (command.vel_z),
    .yaw_rate      (command.yaw_rate),
    .far_mode      (command.far_mode),
    .zero_interval (command.zero_interval)
  );

endmodule

/* design/phpv_check.sv */
`include "assert_macros.svh"

module phpv_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] vel_x
);

  // Sample taken: sequencer leaves idle
  `AST_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)

  // No result word in the cycle right after a sample is taken
  `AST_NEXT(a_no_early_word, clk, rst, in_valid && in_ready, !$rose(out_valid))

  // A new word appears only when the sequencer was busy
  `AST_SAME(a_word_from_work, clk, rst, $rose(out_valid), !$past(in_ready))

  // Stalled word holds
  `AST_NEXT(a_word_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(vel_x))

endmodule

bind position_hold_pid_velocity phpv_check u_phpv_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (command.valid),
  .out_ready (command.ready),
  .vel_x     (command.vel_x)
);
